// ----- rtl/sign_glyph_tokenizer_defines.svh -----
// Assertion macros shared by the sign glyph tokenizer checker.
`ifndef SIGN_GLYPH_TOKENIZER_DEFINES_SVH
`define SIGN_GLYPH_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sign glyph tokenizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sign glyph tokenizer assertion failed");

`endif

// ----- rtl/sgt_pkg.sv -----
// Types and constants shared by the sign glyph tokenizer modules.
package sgt_pkg;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_OUT   = 3'd0,
        MODE_IN    = 3'd1,
        MODE_COMMA = 3'd2,
        MODE_ACCUM = 3'd3,
        MODE_CTRL  = 3'd4,
        MODE_WAIT  = 3'd5
    } t_mode;

    // Result event codes.
    typedef enum logic [1:0] {
        EV_SINGLE = 2'd0,
        EV_MULTI  = 2'd1,
        EV_END    = 2'd2,
        EV_ERROR  = 2'd3
    } t_event;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_FLUSH = 2'd2
    } t_state;

    // Colour codes.
    localparam logic [1:0] COL_Y = 2'd0;
    localparam logic [1:0] COL_L = 2'd1;
    localparam logic [1:0] COL_R = 2'd2;
    localparam logic [1:0] COL_B = 2'd3;

    // Characters with a syntactic role.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_B     = 8'h42;

    // Decoded properties of one character.
    typedef struct packed {
        logic       supported;
        logic       is_nul;
        logic       is_open;
        logic       is_close;
        logic       is_comma;
        logic       is_at;
        logic       ctrl_ok;
        logic [1:0] ctrl_colour;
    } t_char_class;

endpackage

// ----- rtl/sign_glyph_tokenizer.sv -----
// Sign glyph tokenizer top level: parser sequencer, glyph buffer and result register.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------------
//   input    | in        | i_in_valid / o_in_ready   | i_char_in
//   result   | out       | o_out_valid / i_out_ready | o_event_res, o_glyph_char, o_last,
//            |           |                           | o_back_side, o_colour
//
// A character is accepted in the idle state, then decoded and applied in the exec state.
// A closing brace or comma that ends a glyph is followed by a flush state, as the buffer
// memory is read out one character at a time through its single registered read port.
// A result waits in the output register; a stalled result side holds the sequencer only
// when it has another result to deliver.
// Reset is synchronous and active low; no clearing pass is needed.
module sign_glyph_tokenizer
    import sgt_pkg::*;
#(
    parameter int GLYPH_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_event_res,
    output logic [7:0] o_glyph_char,
    output logic       o_last,
    output logic       o_back_side,
    output logic [1:0] o_colour
);

    localparam int IW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
    localparam int CW = $clog2(GLYPH_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(GLYPH_DEPTH);

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic          r_failed, n_failed;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_colour, n_colour;
    logic          r_side, n_side;
    logic [7:0]    r_char, n_char;
    logic [IW-1:0] r_idx, n_idx;

    logic          r_out_valid, n_out_valid;
    t_event        r_out_event, n_out_event;
    logic [7:0]    r_out_char, n_out_char;
    logic          r_out_last, n_out_last;
    logic          r_out_side, n_out_side;
    logic [1:0]    r_out_colour, n_out_colour;

    logic [7:0]    r_glyph_mem [GLYPH_DEPTH];
    logic [7:0]    r_rd_data;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;

    t_char_class   cls;

    // Decode results for the held character.
    logic          d_emit;
    t_event        d_event;
    logic          d_fail;
    logic          d_flush;
    logic          d_end;
    logic          d_wr;
    t_mode         d_mode;
    logic [1:0]    d_colour;
    logic          d_side;
    logic [CW-1:0] d_count;

    logic          slot_free;
    logic          flush_last;

    sgt_char_class u_class (
        .i_char  (r_char),
        .o_class (cls)
    );

    // Parser decision for the held character.
    always_comb begin
        d_emit   = 1'b0;
        d_event  = EV_SINGLE;
        d_fail   = 1'b0;
        d_flush  = 1'b0;
        d_end    = 1'b0;
        d_wr     = 1'b0;
        d_mode   = r_mode;
        d_colour = r_colour;
        d_side   = r_side;
        d_count  = r_count;

        if (cls.is_nul) begin
            d_emit  = 1'b1;
            d_event = EV_END;
            d_end   = 1'b1;
        end else if (r_failed) begin
            d_emit = 1'b0;
        end else if (!cls.supported) begin
            d_fail = 1'b1;
        end else begin
            case (r_mode)
                MODE_OUT: begin
                    if (cls.is_open) begin
                        d_mode = MODE_IN;
                    end else if (cls.is_close) begin
                        d_fail = 1'b1;
                    end else begin
                        d_emit  = 1'b1;
                        d_event = EV_SINGLE;
                    end
                end
                MODE_IN, MODE_COMMA: begin
                    if (cls.is_comma || cls.is_close || cls.is_open) begin
                        d_fail = 1'b1;
                    end else if (cls.is_at) begin
                        d_mode = MODE_CTRL;
                    end else begin
                        d_wr    = 1'b1;
                        d_count = CW'(1);
                        d_mode  = MODE_ACCUM;
                    end
                end
                MODE_ACCUM: begin
                    if (cls.is_close) begin
                        d_flush = 1'b1;
                        d_mode  = MODE_OUT;
                    end else if (cls.is_comma) begin
                        d_flush = 1'b1;
                        d_mode  = MODE_COMMA;
                    end else if (cls.is_open || (r_count >= DEPTH_C)) begin
                        d_fail = 1'b1;
                    end else begin
                        d_wr    = 1'b1;
                        d_count = r_count + CW'(1);
                    end
                end
                MODE_CTRL: begin
                    if (!cls.ctrl_ok) begin
                        d_fail = 1'b1;
                    end else begin
                        if (cls.is_at) begin
                            d_side = 1'b1;
                        end else begin
                            d_colour = cls.ctrl_colour;
                        end
                        d_mode = MODE_WAIT;
                    end
                end
                MODE_WAIT: begin
                    if (cls.is_comma) begin
                        d_mode = MODE_COMMA;
                    end else if (cls.is_close) begin
                        d_mode = MODE_OUT;
                    end else begin
                        d_fail = 1'b1;
                    end
                end
                default: begin
                    d_fail = 1'b1;
                end
            endcase
        end

        // An error emits one result and empties the buffer.
        if (d_fail) begin
            d_emit  = 1'b1;
            d_event = EV_ERROR;
            d_wr    = 1'b0;
            d_count = '0;
            d_mode  = r_mode;
        end
    end

    assign slot_free  = !r_out_valid || i_out_ready;
    assign flush_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign wr_addr    = (r_mode == MODE_ACCUM) ? r_count[IW-1:0] : '0;

    // Sequencer: next state and register updates.
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_failed     = r_failed;
        n_count      = r_count;
        n_colour     = r_colour;
        n_side       = r_side;
        n_char       = r_char;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_event  = r_out_event;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_side   = r_out_side;
        n_out_colour = r_out_colour;
        rd_addr      = r_idx;
        wr_en        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_char  = i_char_in;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!d_emit || slot_free) begin
                    if (d_emit) begin
                        n_out_valid  = 1'b1;
                        n_out_event  = d_event;
                        n_out_char   = (d_event == EV_END) ? CH_NUL : r_char;
                        n_out_last   = 1'b0;
                        n_out_side   = r_side;
                        n_out_colour = r_colour;
                    end
                    if (d_end) begin
                        n_mode   = MODE_OUT;
                        n_failed = 1'b0;
                        n_count  = '0;
                        n_colour = COL_Y;
                        n_side   = 1'b0;
                    end else begin
                        n_mode   = d_mode;
                        n_failed = r_failed || d_fail;
                        n_count  = d_count;
                        n_colour = d_colour;
                        n_side   = d_side;
                    end
                    wr_en = d_wr;
                    if (d_flush) begin
                        n_idx   = '0;
                        rd_addr = '0;
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_event  = EV_MULTI;
                    n_out_char   = r_rd_data;
                    n_out_last   = flush_last;
                    n_out_side   = r_side;
                    n_out_colour = r_colour;
                    if (flush_last) begin
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        rd_addr = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_OUT;
            r_failed    <= 1'b0;
            r_count     <= '0;
            r_colour    <= COL_Y;
            r_side      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_failed    <= n_failed;
            r_count     <= n_count;
            r_colour    <= n_colour;
            r_side      <= n_side;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_char       <= n_char;
        r_out_event  <= n_out_event;
        r_out_char   <= n_out_char;
        r_out_last   <= n_out_last;
        r_out_side   <= n_out_side;
        r_out_colour <= n_out_colour;
    end

    // Glyph buffer: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_glyph_mem[wr_addr] <= r_char;
        end
        r_rd_data <= r_glyph_mem[rd_addr];
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_out_event;
    assign o_glyph_char = r_out_char;
    assign o_last       = r_out_last;
    assign o_back_side  = r_out_side;
    assign o_colour     = r_out_colour;

endmodule

// ----- rtl/sgt_char_class.sv -----
// Character classifier: supported set and syntactic roles of one character.
module sgt_char_class
    import sgt_pkg::*;
(
    input  logic [7:0]  i_char,
    output t_char_class o_class
);

    // Supported set: upper case, digits, a few punctuation marks and a subset of lower case letters.
    always_comb begin
        o_class = '0;
        case (i_char) inside
            [8'h41:8'h5A], [8'h30:8'h39],
            8'h2E, 8'h2A, 8'h2D, 8'h5F, 8'h7C, 8'h2F, 8'h5E,
            CH_COMMA, CH_AT, CH_OPEN, CH_CLOSE,
            8'h61, [8'h63:8'h66], 8'h68, 8'h69, [8'h6C:8'h6F],
            [8'h72:8'h75], 8'h79, 8'h7A: begin
                o_class.supported = 1'b1;
            end
            default: begin
                o_class.supported = 1'b0;
            end
        endcase

        o_class.is_nul   = (i_char == CH_NUL);
        o_class.is_open  = (i_char == CH_OPEN);
        o_class.is_close = (i_char == CH_CLOSE);
        o_class.is_comma = (i_char == CH_COMMA);
        o_class.is_at    = (i_char == CH_AT);

        // Second character of a control code.
        case (i_char)
            CH_Y: begin
                o_class.ctrl_ok     = 1'b1;
                o_class.ctrl_colour = COL_Y;
            end
            CH_L: begin
                o_class.ctrl_ok     = 1'b1;
                o_class.ctrl_colour = COL_L;
            end
            CH_R: begin
                o_class.ctrl_ok     = 1'b1;
                o_class.ctrl_colour = COL_R;
            end
            CH_B: begin
                o_class.ctrl_ok     = 1'b1;
                o_class.ctrl_colour = COL_B;
            end
            CH_AT: begin
                o_class.ctrl_ok     = 1'b1;
                o_class.ctrl_colour = COL_Y;
            end
            default: begin
                o_class.ctrl_ok     = 1'b0;
                o_class.ctrl_colour = COL_Y;
            end
        endcase
    end

endmodule

// ----- rtl/sgt_checker.sv -----
// Port-level checker for the sign glyph tokenizer, bound to the top level.
`include "sign_glyph_tokenizer_defines.svh"

module sgt_checker
    import sgt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_char_in,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_event_res,
    input logic [7:0] o_glyph_char,
    input logic       o_last,
    input logic       o_back_side,
    input logic [1:0] o_colour
);

    logic        in_take;
    logic        in_wait;
    logic        out_stall;
    logic [13:0] out_payload;

    assign in_take     = i_in_valid && o_in_ready;
    assign in_wait     = i_in_valid && !o_in_ready;
    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_payload = {o_event_res, o_glyph_char, o_last, o_back_side, o_colour};

    // A waiting request keeps its character.
    `SGT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(i_char_in))

    // A held result keeps its payload.
    `SGT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_payload))

    // The block works on one character at a time.
    `SGT_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, !o_in_ready)

    // An end result carries a NUL character and no run marker.
    `SGT_ASSERT_NOW(a_end_payload, i_clk, i_rst_n, o_out_valid && (o_event_res == EV_END), (o_glyph_char == CH_NUL) && !o_last)

    // Only a multi-letter glyph run marks its final character.
    `SGT_ASSERT_NOW(a_last_multi, i_clk, i_rst_n, o_out_valid && o_last, o_event_res == EV_MULTI)

endmodule

bind sign_glyph_tokenizer sgt_checker u_sgt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_char_in    (i_char_in),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_event_res  (o_event_res),
    .o_glyph_char (o_glyph_char),
    .o_last       (o_last),
    .o_back_side  (o_back_side),
    .o_colour     (o_colour)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sign glyph tokenizer, driven with random sign strings.
module tb;
    import sgt_pkg::*;

    localparam int GLYPH_DEPTH  = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 82;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    // One predicted result, field for field as the block presents it.
    typedef struct {
        t_event     ev;
        logic [7:0] ch;
        logic       last;
        logic       side;
        logic [1:0] colour;
    } t_glyph_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_char_in;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_event_res;
    logic [7:0] o_glyph_char;
    logic       o_last;
    logic       o_back_side;
    logic [1:0] o_colour;

    sign_glyph_tokenizer #(
        .GLYPH_DEPTH (GLYPH_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_in    (i_char_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_glyph_char (o_glyph_char),
        .o_last       (o_last),
        .o_back_side  (o_back_side),
        .o_colour     (o_colour)
    );

    // Tokenizer state as the testbench tracks it.
    t_mode      tok_mode;
    logic       tok_failed;
    logic [7:0] tok_buf [GLYPH_DEPTH];
    int         tok_count;
    logic [1:0] tok_colour;
    logic       tok_side;

    logic [7:0]    char_q [$];
    t_glyph_result expected_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    bit req_taken     = 1'b0;
    int cycle_cnt     = 0;
    int chars_sent    = 0;
    int results_seen  = 0;
    int error_results = 0;
    int multi_results = 0;
    int strings_built = 0;
    int err_cnt       = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Characters the sign alphabet accepts.
    function automatic bit is_supported(input logic [7:0] c);
        string extras = ".*,-_|/@^{}acdefhilmnorstuyz";
        if (c >= "A" && c <= "Z") return 1'b1;
        if (c >= "0" && c <= "9") return 1'b1;
        for (int i = 0; i < extras.len(); i++) begin
            if (extras[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void reset_tokenizer();
        tok_mode   = MODE_OUT;
        tok_failed = 1'b0;
        tok_count  = 0;
        tok_colour = COL_Y;
        tok_side   = 1'b0;
    endfunction

    function automatic void push_result(input t_event ev, input logic [7:0] ch,
                                        input logic last);
        t_glyph_result r;
        r.ev     = ev;
        r.ch     = ch;
        r.last   = last;
        r.side   = tok_side;
        r.colour = tok_colour;
        expected_q.push_back(r);
    endfunction

    // An error empties the buffer and swallows everything up to the next NUL.
    function automatic void raise_error(input logic [7:0] c);
        tok_failed = 1'b1;
        tok_count  = 0;
        push_result(EV_ERROR, c, 1'b0);
    endfunction

    // Emit the buffered multi-letter glyph, marking its final character.
    function automatic void emit_glyph();
        for (int i = 0; i < tok_count; i++) begin
            push_result(EV_MULTI, tok_buf[i], i == tok_count - 1);
        end
        tok_count = 0;
    endfunction

    // Work out the results one accepted character causes.
    function automatic void tokenize_char(input logic [7:0] c);
        if (c == CH_NUL) begin
            push_result(EV_END, CH_NUL, 1'b0);
            reset_tokenizer();
            return;
        end
        if (tok_failed) return;
        if (!is_supported(c)) begin
            raise_error(c);
            return;
        end
        case (tok_mode)
            MODE_OUT: begin
                if (c == CH_OPEN) tok_mode = MODE_IN;
                else if (c == CH_CLOSE) raise_error(c);
                else push_result(EV_SINGLE, c, 1'b0);
            end
            MODE_IN, MODE_COMMA: begin
                if (c == CH_COMMA || c == CH_CLOSE || c == CH_OPEN) begin
                    raise_error(c);
                end else if (c == CH_AT) begin
                    tok_mode = MODE_CTRL;
                end else begin
                    tok_buf[0] = c;
                    tok_count  = 1;
                    tok_mode   = MODE_ACCUM;
                end
            end
            MODE_ACCUM: begin
                if (c == CH_CLOSE) begin
                    emit_glyph();
                    tok_mode = MODE_OUT;
                end else if (c == CH_COMMA) begin
                    emit_glyph();
                    tok_mode = MODE_COMMA;
                end else if (c == CH_OPEN || tok_count >= GLYPH_DEPTH) begin
                    raise_error(c);
                end else begin
                    tok_buf[tok_count] = c;
                    tok_count++;
                end
            end
            MODE_CTRL: begin
                tok_mode = MODE_WAIT;
                if (c == CH_Y) tok_colour = COL_Y;
                else if (c == CH_L) tok_colour = COL_L;
                else if (c == CH_R) tok_colour = COL_R;
                else if (c == CH_B) tok_colour = COL_B;
                else if (c == CH_AT) tok_side = 1'b1;
                else raise_error(c);
            end
            MODE_WAIT: begin
                if (c == CH_COMMA) tok_mode = MODE_COMMA;
                else if (c == CH_CLOSE) tok_mode = MODE_OUT;
                else raise_error(c);
            end
            default: raise_error(c);
        endcase
    endfunction

    // A supported character with no syntactic role.
    function automatic logic [7:0] pick_glyph_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(33, 126));
        end while (!is_supported(c) || c == CH_OPEN || c == CH_CLOSE
                   || c == CH_COMMA || c == CH_AT);
        return c;
    endfunction

    function automatic void push_text(input string t);
        for (int i = 0; i < t.len(); i++) char_q.push_back(t[i]);
    endfunction

    // Queue one NUL-terminated sign string; mostly well formed, sometimes broken.
    function automatic int build_sign();
        logic [7:0] s [$];
        int         parts;
        int         elems;
        int         len;
        int         pick;
        int         pos;
        parts = $urandom_range(1, 4);
        for (int p = 0; p < parts; p++) begin
            if ($urandom_range(2) == 0) begin
                // Plain glyphs outside braces; comma and at-sign are plain here.
                len = $urandom_range(1, 3);
                repeat (len) begin
                    pick = $urandom_range(9);
                    s.push_back(pick == 0 ? CH_AT : pick == 1 ? CH_COMMA : pick_glyph_char());
                end
            end else begin
                s.push_back(CH_OPEN);
                elems = $urandom_range(1, 3);
                for (int e = 0; e < elems; e++) begin
                    if (e > 0) s.push_back(CH_COMMA);
                    if ($urandom_range(9) < 3) begin
                        s.push_back(CH_AT);
                        case ($urandom_range(4))
                            0:       s.push_back(CH_Y);
                            1:       s.push_back(CH_L);
                            2:       s.push_back(CH_R);
                            3:       s.push_back(CH_B);
                            default: s.push_back(CH_AT);
                        endcase
                    end else begin
                        pick = $urandom_range(15);
                        if (pick == 0) len = GLYPH_DEPTH + 1;
                        else if (pick < 3) len = $urandom_range(5, GLYPH_DEPTH);
                        else len = $urandom_range(1, 4);
                        repeat (len) s.push_back(pick_glyph_char());
                    end
                end
                s.push_back(CH_CLOSE);
            end
        end
        // Break the syntax or inject a stray byte now and then.
        if ($urandom_range(99) < 20) begin
            pos = $urandom_range(s.size() - 1);
            case ($urandom_range(4))
                0:       s[pos] = CH_OPEN;
                1:       s[pos] = CH_CLOSE;
                2:       s[pos] = CH_COMMA;
                3:       s[pos] = CH_AT;
                default: s[pos] = 8'($urandom_range(255));
            endcase
        end
        // Occasional string of pure noise.
        if ($urandom_range(99) < 5) begin
            s.delete();
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
        end
        foreach (s[i]) char_q.push_back(s[i]);
        char_q.push_back(CH_NUL);
        strings_built++;
        return s.size() + 1;
    endfunction

    // Request driver: presents queued characters at the falling edge.
    always @(negedge i_clk) begin : drive_req
        logic       nv;
        logic [7:0] nc;
        nv = i_in_valid;
        nc = i_char_in;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (req_taken) nv = 1'b0;
            if (!nv && char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nv = 1'b1;
                nc = char_q.pop_front();
            end
        end
        req_taken = 1'b0;
        i_in_valid  <= nv;
        i_char_in   <= nc;
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict the results of each accepted request.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            tokenize_char(i_char_in);
            chars_sent++;
            req_taken = 1'b1;
        end
    end

    // Result monitor: compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_glyph_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_event_res == EV_ERROR) error_results++;
            if (o_event_res == EV_MULTI) multi_results++;
            if (expected_q.size() == 0) begin
                if (err_cnt < REPORT_MAX)
                    $display("unexpected result: ev %0d char %02h last %0b side %0b colour %0d",
                             o_event_res, o_glyph_char, o_last, o_back_side,
                             o_colour);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (o_event_res !== want.ev || o_glyph_char !== want.ch
                    || o_last !== want.last || o_back_side !== want.side
                    || o_colour !== want.colour) begin
                    if (err_cnt < REPORT_MAX) begin
                        $display("result %0d mismatch:", results_seen);
                        $display("    expected ev %0d char %02h last %0b side %0b colour %0d",
                                 want.ev, want.ch, want.last, want.side, want.colour);
                        $display("    got ev %0d char %02h last %0b side %0b colour %0d",
                                 o_event_res, o_glyph_char, o_last, o_back_side,
                                 o_colour);
                    end
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus sequence and end of run.
    initial begin : run_test
        int queued;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_char_in      = CH_NUL;
        i_out_ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        reset_tokenizer();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single glyph, a colour code and back side, a flushed glyph,
        // a character above the printable range, swallowing after an error, and overflow.
        push_text("Z{@R,@@,XY}");
        char_q.push_back(8'hFF);
        push_text("}");
        char_q.push_back(CH_NUL);
        push_text("{ABCDEFGHI");
        char_q.push_back(CH_NUL);

        // Random strings under four idling patterns.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            queued = 0;
            while (queued < PHASE_ITEMS) queued += build_sign();
            while (char_q.size() != 0) @(posedge i_clk);
        end

        while (i_in_valid || expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_cnt += expected_q.size();

        $display("Sent %0d characters in %0d sign strings over four idling patterns.",
                 chars_sent, strings_built);
        $display("Checked %0d results, %0d of them glyph-run characters and %0d errors.",
                 results_seen, multi_results, error_results);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
